// File: src/firft_pkg.sv
// Shared constants, coefficient table and controller/datapath interface types for the FIR unit.
package firft_pkg;

  localparam int unsigned TAP_COUNT_DEF = 198;
  localparam int unsigned COEF_COUNT    = 198;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned COEF_W        = 16;
  localparam int unsigned PROD_W        = SAMPLE_W + COEF_W;
  localparam int unsigned OUT_SHIFT     = 16;
  localparam int unsigned TAP_IDX_W     = 16;

  localparam logic signed [COEF_W-1:0] COEF_ROM [COEF_COUNT] = '{
    -16'sd7, -16'sd3, -16'sd4, -16'sd5, -16'sd6, -16'sd6, -16'sd7, -16'sd7, -16'sd8, -16'sd8,
    -16'sd7, -16'sd7, -16'sd5, -16'sd4, -16'sd1, 16'sd2, 16'sd6, 16'sd10,
    16'sd16, 16'sd22, 16'sd29, 16'sd38, 16'sd47, 16'sd57, 16'sd68, 16'sd80, 16'sd93,
    16'sd106, 16'sd120, 16'sd134, 16'sd149, 16'sd163, 16'sd177,
    16'sd190, 16'sd203, 16'sd215, 16'sd225, 16'sd234, 16'sd241, 16'sd246, 16'sd249,
    16'sd249, 16'sd247, 16'sd242, 16'sd234, 16'sd222, 16'sd208,
    16'sd190, 16'sd170, 16'sd147, 16'sd121, 16'sd93, 16'sd62, 16'sd30, -16'sd4, -16'sd38,
    -16'sd73, -16'sd108, -16'sd141, -16'sd174, -16'sd204,
    -16'sd232, -16'sd256, -16'sd277, -16'sd293, -16'sd303, -16'sd309, -16'sd308, -16'sd300,
    -16'sd286, -16'sd265, -16'sd237,
    -16'sd201, -16'sd159, -16'sd109, -16'sd52, 16'sd11, 16'sd80, 16'sd155, 16'sd234,
    16'sd317, 16'sd404, 16'sd493, 16'sd584, 16'sd675,
    16'sd766, 16'sd855, 16'sd942, 16'sd1025, 16'sd1104, 16'sd1177, 16'sd1244, 16'sd1304,
    16'sd1356, 16'sd1399, 16'sd1433, 16'sd1458,
    16'sd1473, 16'sd1478, 16'sd1473, 16'sd1458, 16'sd1433, 16'sd1399, 16'sd1356, 16'sd1304,
    16'sd1244, 16'sd1177, 16'sd1104,
    16'sd1025, 16'sd942, 16'sd855, 16'sd766, 16'sd675, 16'sd584, 16'sd493, 16'sd404,
    16'sd317, 16'sd234, 16'sd155, 16'sd80, 16'sd11, -16'sd52,
    -16'sd109, -16'sd159, -16'sd201, -16'sd237, -16'sd265, -16'sd286, -16'sd300, -16'sd308,
    -16'sd309, -16'sd303, -16'sd293,
    -16'sd277, -16'sd256, -16'sd232, -16'sd204, -16'sd174, -16'sd141, -16'sd108, -16'sd73,
    -16'sd38, -16'sd4, 16'sd30, 16'sd62, 16'sd93,
    16'sd121, 16'sd147, 16'sd170, 16'sd190, 16'sd208, 16'sd222, 16'sd234, 16'sd242,
    16'sd247, 16'sd249, 16'sd249, 16'sd246, 16'sd241, 16'sd234,
    16'sd225, 16'sd215, 16'sd203, 16'sd190, 16'sd177, 16'sd163, 16'sd149, 16'sd134,
    16'sd120, 16'sd106, 16'sd93, 16'sd80, 16'sd68, 16'sd57, 16'sd47,
    16'sd38, 16'sd29, 16'sd22, 16'sd16, 16'sd10, 16'sd6, 16'sd2, -16'sd1, -16'sd4, -16'sd5,
    -16'sd7, -16'sd7, -16'sd8, -16'sd8, -16'sd7, -16'sd7, -16'sd6, -16'sd6,
    -16'sd5, -16'sd4, -16'sd3, -16'sd7, -16'sd7
  };

  // Taps past the end of the stored table have a zero coefficient.
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_IDX_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (k < TAP_IDX_W'(COEF_COUNT)) begin
      c = COEF_ROM[k[7:0]];
    end
    return c;
  endfunction

  typedef struct packed {
    logic load;   // write the new sample and start a new sum
    logic step;   // issue one tap into the multiply-accumulate pipeline
    logic emit;   // move the finished sum into the output register
  } cmd_t;

  typedef struct packed {
    logic last_tap;   // the tap being issued now is the final one
    logic pipe_busy;  // taps are still in flight toward the accumulator
  } status_t;

endpackage

// File: src/firft_ctrl.sv
// Sequencing state machine and handshake control for the FIR unit.
module firft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  firft_pkg::status_t st,
  output firft_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_FLUSH = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        cmd.step = 1'b1;
        if (st.last_tap) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!st.pipe_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: src/firft_datapath.sv
// Sample history memory, tap addressing, shared multiplier, accumulator and output register.
module firft_datapath #(
  parameter int unsigned TAP_COUNT = firft_pkg::TAP_COUNT_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic signed [firft_pkg::SAMPLE_W-1:0]      sample_in,
  input  firft_pkg::cmd_t                            cmd,
  output firft_pkg::status_t                         st,
  output logic signed [firft_pkg::SAMPLE_W-1:0]      sample_out,
  output logic                                       overflow
);

  localparam int unsigned AW    = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int unsigned CW    = $clog2(TAP_COUNT + 1);
  localparam int unsigned ACC_W = firft_pkg::PROD_W + $clog2(TAP_COUNT) + 1;
  localparam int unsigned SW    = firft_pkg::SAMPLE_W;
  localparam int unsigned SH    = firft_pkg::OUT_SHIFT;

  logic signed [SW-1:0] mem [TAP_COUNT];

  logic [AW-1:0] wr_pos;
  logic [CW-1:0] fill;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] k;

  logic                                   v1;
  logic                                   v2;
  logic signed [SW-1:0]                   rd_data;
  logic                                   rd_ok;
  logic signed [firft_pkg::COEF_W-1:0]    coef_q;
  logic signed [firft_pkg::PROD_W-1:0]    prod;
  logic signed [ACC_W-1:0]                acc;
  logic signed [SW-1:0]                   sample_eff;
  logic [ACC_W-1-(SH+SW-1):0]             acc_top;

  assign st.last_tap  = (k == AW'(TAP_COUNT - 1));
  assign st.pipe_busy = v1 | v2;

  // Entries are written in address order from reset, so anything at or above the
  // fill count has not been written yet and is read as zero.
  assign sample_eff = rd_ok ? rd_data : '0;
  assign acc_top    = acc[ACC_W-1:SH+SW-1];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[wr_pos] <= sample_in;
    end
    if (cmd.step) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= '0;
      fill   <= '0;
      v1     <= 1'b0;
      v2     <= 1'b0;
    end else begin
      if (cmd.load) begin
        wr_pos <= (wr_pos == AW'(TAP_COUNT - 1)) ? '0 : wr_pos + 1'b1;
        if (fill != CW'(TAP_COUNT)) begin
          fill <= fill + 1'b1;
        end
      end
      v1 <= cmd.step;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_ptr <= wr_pos;
      k      <= '0;
      acc    <= '0;
    end else begin
      if (cmd.step) begin
        rd_ptr <= (rd_ptr == '0) ? AW'(TAP_COUNT - 1) : rd_ptr - 1'b1;
        k      <= k + 1'b1;
        rd_ok  <= (CW'(rd_ptr) < fill);
        coef_q <= firft_pkg::coef_at(firft_pkg::TAP_IDX_W'(k));
      end
      if (v2) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    if (v1) begin
      prod <= sample_eff * coef_q;
    end
    if (cmd.emit) begin
      sample_out <= acc[SH+SW-1:SH];
      overflow   <= (acc_top != '0) && (acc_top != '1);
    end
  end

endmodule

// File: src/fir_filter_fixed_taps_unit.sv
// Top level of the fixed-coefficient direct-form FIR filter unit.
//
// Direct-form FIR filter over signed 16-bit samples with TAP_COUNT fixed 16-bit
// coefficients held in a constant table. Each accepted sample is written into a
// circular history memory. The unit then forms the exact sum of coefficient[k]
// times the sample k steps back, with coefficient 0 taking the newest sample.
// The sum is shifted right arithmetically by 16. sample_out carries the low 16
// bits of that value, and overflow is set when the value did not fit in 16 bits.
// Exactly one result transfer follows each input transfer. The history memory has a
// single read port feeding one shared 16 x 16 multiplier, so one tap is processed
// per cycle. The read, multiply and accumulate stages are then drained and the
// output register is loaded. The input is stalled from each input transfer until
// its result has been loaded into the output register. The stall lasts longer
// when that result has to wait for the previous one to leave. The output register
// lets a finished result wait while the next sample is taken and filtered. After
// reset the history reads as all zeros. A fill count marks the entries not yet
// written, so no clearing pass is needed and the unit is ready at once.
module fir_filter_fixed_taps_unit #(
  parameter int unsigned TAP_COUNT = firft_pkg::TAP_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [firft_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  output logic signed [firft_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                  overflow,
  output logic                                  out_valid,
  input  logic                                  out_stall
);

  // Command and status between the sequencer and the arithmetic.
  firft_pkg::cmd_t    cmd;
  firft_pkg::status_t st;

  // The controller owns both handshakes and walks each sample through
  // load, tap issue, pipeline drain and result hand-off.
  firft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds the sample history, the shared multiplier, the
  // accumulator and the output register.
  firft_datapath #(
    .TAP_COUNT (TAP_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_in),
    .cmd        (cmd),
    .st         (st),
    .sample_out (sample_out),
    .overflow   (overflow)
  );

endmodule

// File: sim/fir_output_checker.sv
// Checker for the FIR unit: predicts each filtered sample and compares the result stream.
module fir_output_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [firft_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [firft_pkg::SAMPLE_W-1:0] sample_out,
  input  logic                                  overflow,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  output int unsigned                           mismatch_count,
  output int unsigned                           outstanding
);

  localparam int unsigned TAPS = firft_pkg::TAP_COUNT_DEF;

  typedef struct packed {
    logic signed [firft_pkg::SAMPLE_W-1:0] sample;
    logic                                  wrapped;
  } filter_out_t;

  logic signed [firft_pkg::SAMPLE_W-1:0] delay_line [TAPS];
  int unsigned                           write_slot;
  filter_out_t                           expected_outputs [$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  // Writes the new sample into the delay line and returns the filter output it causes.
  function automatic filter_out_t filter_next(
    input logic signed [firft_pkg::SAMPLE_W-1:0] x
  );
    filter_out_t r;
    longint      acc;
    longint      scaled;
    int unsigned head;
    int unsigned slot;
    head = write_slot;
    delay_line[head] = x;
    write_slot = (head + 1 == TAPS) ? 0 : head + 1;
    acc = 0;
    for (int unsigned k = 0; k < TAPS; k++) begin
      slot = (head + TAPS - k) % TAPS;
      if (k < firft_pkg::COEF_COUNT) begin
        acc += longint'(firft_pkg::COEF_ROM[k]) * longint'(delay_line[slot]);
      end
    end
    scaled    = acc >>> firft_pkg::OUT_SHIFT;
    r.sample  = scaled[firft_pkg::SAMPLE_W-1:0];
    r.wrapped = (scaled < -32768 || scaled > 32767);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    filter_out_t want;
    if (rst) begin
      expected_outputs.delete();
      for (int unsigned i = 0; i < TAPS; i++) begin
        delay_line[i] = '0;
      end
      write_slot = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_outputs.push_back(filter_next(sample_in));
      end
      if (out_valid && !out_stall) begin
        if (expected_outputs.size() == 0) begin
          $error("unexpected result transfer: sample_out %0d overflow %0b",
                 sample_out, overflow);
          mismatch_count++;
        end else begin
          want = expected_outputs.pop_front();
          if (sample_out !== want.sample) begin
            $error("sample_out mismatch: expected %0d, actual %0d", want.sample, sample_out);
            mismatch_count++;
          end
          if (overflow !== want.wrapped) begin
            $error("overflow mismatch: expected %0b, actual %0b", want.wrapped, overflow);
            mismatch_count++;
          end
        end
      end
    end
    outstanding = expected_outputs.size();
  end

endmodule

// File: sim/tb_top.sv
// Testbench top for the FIR unit: clock, reset, sample stimulus, result back-pressure, verdict.
module tb_top;

  localparam int unsigned TAPS         = firft_pkg::TAP_COUNT_DEF;
  localparam int unsigned ITEM_TARGET  = 1950;
  // The long receiver hold-off starts once this many samples have gone in.
  localparam int unsigned HOLD_OFF_AT  = 150;
  localparam int unsigned HOLD_OFF_LEN = 1500;
  // Time to wait after the last result for any stray transfer to show.
  localparam int unsigned DRAIN_CYCLES = 2 * (TAPS + 5);

  // Kinds of sample bursts in the random part.
  typedef enum logic [2:0] {
    BURST_RANDOM,
    BURST_EXTREME,
    BURST_SMALL,
    BURST_RAMP,
    BURST_MATCHED
  } burst_kind_t;

  logic                                  clk;
  logic                                  rst;
  logic signed [firft_pkg::SAMPLE_W-1:0] sample_in;
  logic                                  in_valid;
  logic                                  in_stall;
  logic signed [firft_pkg::SAMPLE_W-1:0] sample_out;
  logic                                  overflow;
  logic                                  out_valid;
  logic                                  out_stall;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned sent_count;
  bit          held_off;

  fir_filter_fixed_taps_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_in),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_out (sample_out),
    .overflow   (overflow),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

  fir_output_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .sample_in      (sample_in),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample_out     (sample_out),
    .overflow       (overflow),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // All inputs start at known values; reset is held at the start and then released.
  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    sample_in  = '0;
    in_valid   = 1'b0;
    out_stall  = 1'b0;
    sent_count = 0;
    held_off   = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly back-to-back or short gaps, now and then a long one. A long gap can outlast
  // a full pass over the taps, so over the run the gaps land on every phase of the
  // multiply-accumulate sequence.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 60);
    return $urandom_range(100, 400);
  endfunction

  // Offers one sample and holds it until the transfer happens. The valid is only
  // lowered when an idle gap follows, so a back-to-back sample keeps it high.
  task automatic offer_sample(input logic signed [firft_pkg::SAMPLE_W-1:0] s,
                              input bit may_idle);
    int unsigned gap;
    sample_in <= s;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_count++;
    gap = may_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender: a short directed run, then random bursts, then the drain and the verdict.
  initial begin : sender
    logic signed [firft_pkg::SAMPLE_W-1:0] directed [24];
    logic signed [firft_pkg::SAMPLE_W-1:0] ramp;
    logic signed [firft_pkg::SAMPLE_W-1:0] ramp_step;
    logic signed [firft_pkg::SAMPLE_W-1:0] extremes [5];
    burst_kind_t                           kind;
    int unsigned                           pick;
    int unsigned                           burst_len;
    bit                                    may_idle;
    bit                                    invert;

    // Both rails, zero, unit steps and alternating bit patterns, followed by
    // runs at the positive and negative rails that push the sum toward its limits.
    directed = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sh5555,
                 16'shAAAA, 16'sh00FF, 16'shFF00,
                 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                 16'sh7FFF, 16'sh7FFF,
                 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                 16'sh8000};
    extremes = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001};

    do @(posedge clk); while (rst);

    foreach (directed[i]) begin
      offer_sample(directed[i], 1'b1);
    end

    ramp = '0;
    while (sent_count < ITEM_TARGET) begin
      pick      = $urandom_range(0, 99);
      burst_len = $urandom_range(20, 120);
      // About a quarter of the bursts go with no idle cycles at all on the input.
      may_idle  = ($urandom_range(0, 3) != 0);
      if (pick < 8) kind = BURST_MATCHED;
      else if (pick < 55) kind = BURST_RANDOM;
      else if (pick < 70) kind = BURST_EXTREME;
      else if (pick < 85) kind = BURST_SMALL;
      else kind = BURST_RAMP;

      case (kind)
        BURST_MATCHED: begin
          // A full window of rail samples whose signs follow the coefficient signs,
          // aligned so the last one meets tap 0. This drives the output to its
          // largest magnitude; inverting the pattern gives the negative extreme.
          invert = $urandom_range(0, 1);
          for (int unsigned j = 0; j < TAPS; j++) begin
            if ((firft_pkg::COEF_ROM[TAPS-1-j] >= 0) ^ invert) begin
              offer_sample(16'sh7FFF, may_idle);
            end else begin
              offer_sample(16'sh8000, may_idle);
            end
          end
        end
        BURST_EXTREME: begin
          for (int unsigned j = 0; j < burst_len; j++) begin
            offer_sample(extremes[$urandom_range(0, 4)], may_idle);
          end
        end
        BURST_SMALL: begin
          for (int unsigned j = 0; j < burst_len; j++) begin
            offer_sample(firft_pkg::SAMPLE_W'($urandom_range(0, 16)) - 16'sd8, may_idle);
          end
        end
        BURST_RAMP: begin
          // A sawtooth that wraps through both rails at a random slope.
          ramp_step = firft_pkg::SAMPLE_W'($urandom_range(1, 4000));
          for (int unsigned j = 0; j < burst_len; j++) begin
            ramp = ramp + ramp_step;
            offer_sample(ramp, may_idle);
          end
        end
        default: begin
          for (int unsigned j = 0; j < burst_len; j++) begin
            offer_sample(firft_pkg::SAMPLE_W'($urandom_range(0, 65535)), may_idle);
          end
        end
      endcase
    end
    in_valid <= 1'b0;

    // Wait for every predicted result, then give the unit time to show any stray one.
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver: random ready and stall stretches. Once, early in the run, it holds off
  // for a long stretch while the sender keeps offering samples, so the output
  // register fills, the next sum completes behind it and the unit stalls its input.
  initial begin : receiver
    int unsigned ready_len;
    int unsigned stall_len;
    do @(posedge clk); while (rst);
    forever begin
      if (!held_off && sent_count >= HOLD_OFF_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        held_off = 1'b1;
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          ready_len = $urandom_range(200, 800);
        end else begin
          ready_len = $urandom_range(1, 8);
        end
        out_stall <= 1'b0;
        repeat (ready_len) @(posedge clk);
        stall_len = pick_gap();
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  // Run limit, far above the slowest legal run: every item waiting out the longest
  // input gap, the longest output stall and its own pass over the taps.
  initial begin : run_limit
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
